/* sv/fpc_pkg.sv */
// Shared types and constants for the fern posterior classifier.
package fpc_pkg;

    localparam int NUM_FERNS  = 10;
    localparam int NUM_TESTS  = 13;
    localparam int COUNT_BITS = 16;

    localparam int CODE_W  = 13;
    localparam int THR_W   = 17;
    localparam int SUM_W   = 20;
    localparam int FRAC_W  = 16;
    localparam int POST_W  = FRAC_W + 1;
    localparam int CNT_W   = COUNT_BITS;
    localparam int SCALE   = 10;

    localparam int FERN_W    = (NUM_FERNS > 1) ? $clog2(NUM_FERNS) : 1;
    localparam int ADDR_W    = FERN_W + NUM_TESTS;
    localparam int TBL_DEPTH = NUM_FERNS << NUM_TESTS;

    localparam int ACC_W = $clog2(NUM_FERNS * (1 << FRAC_W) + 1);
    localparam int LIM_W = THR_W + $clog2(NUM_FERNS + 1);
    localparam int CMP_W = (ACC_W > LIM_W) ? ((ACC_W > SUM_W) ? ACC_W : SUM_W)
                                           : ((LIM_W > SUM_W) ? LIM_W : SUM_W);

    localparam int NUMHI_W = CNT_W + 4;
    localparam int DEN_W   = CNT_W + 5;
    localparam int QCNT_W  = $clog2(POST_W + 1);

    localparam logic [THR_W-1:0]  THR_RESET = THR_W'(32768);
    localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [POST_W-1:0] POST_MAX  = POST_W'(1 << FRAC_W);

    typedef struct packed {
        logic [POST_W-1:0] post;
        logic [CNT_W-1:0]  pos_cnt;
        logic [CNT_W-1:0]  neg_cnt;
    } t_entry;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        t_entry            wr_data;
    } t_tbl_req;

    typedef struct packed {
        logic               start;
        logic [NUMHI_W-1:0] num_hi;
        logic [DEN_W-1:0]   den;
    } t_div_req;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SUM,
        S_DECIDE,
        S_UPD_RD,
        S_UPD_CALC,
        S_UPD_PREP,
        S_UPD_DIV
    } t_state;

endpackage

/* sv/fpc_table.sv */
// Posterior and count table: one synchronous memory with a clearing sweep after reset.
module fpc_table import fpc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_tbl_req i_req,
    output t_entry   o_rd_data,
    output logic     o_busy
);

    t_entry            mem [TBL_DEPTH];
    t_entry            r_rd_data;
    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    t_entry            wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == ADDR_W'(TBL_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_comb begin
        if (r_clearing) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = i_req.wr_en;
            wr_addr = i_req.wr_addr;
            wr_data = i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clearing;

endmodule

/* sv/fpc_div.sv */
// Restoring divider, one quotient bit per cycle, for the Q1.16 posterior.
module fpc_div import fpc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_req          i_req,
    output logic              o_done,
    output logic [POST_W-1:0] o_quo
);

    logic              r_busy;
    logic              r_done;
    logic [QCNT_W-1:0] r_cnt;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;
    logic [POST_W-1:0] r_bits;
    logic [POST_W-1:0] r_quo;
    logic [DEN_W:0]    trial;
    logic              ge;
    logic [DEN_W-1:0]  n_rem;

    // remainder stays below the divisor, so the trial value fits one extra bit
    always_comb begin
        trial = {r_rem, r_bits[POST_W-1]};
        ge    = trial >= {1'b0, r_den};
        n_rem = ge ? DEN_W'(trial - {1'b0, r_den}) : DEN_W'(trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= QCNT_W'(POST_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == QCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_den  <= i_req.den;
            r_rem  <= DEN_W'(i_req.num_hi >> 1);
            r_bits <= {i_req.num_hi[0], {FRAC_W{1'b0}}};
            r_quo  <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_bits <= {r_bits[POST_W-2:0], 1'b0};
            r_quo  <= {r_quo[POST_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

/* sv/fern_posterior_classifier_unit.sv */
// Random ferns classifier: posterior lookup, decision and online count update.
// Flow: one code is taken per cycle while idle; the result of a sample goes through the
// table read, the accumulator and the output register, which waits until the output is
// free. A learn update then walks all ferns (read, count, setup, divider steps, write).
// Reset: all NUM_FERNS << NUM_TESTS entries (81920 here) are swept to zero, one entry a
// cycle; no code word is taken until the sweep ends, config always is.
module fern_posterior_classifier_unit import fpc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_cmd,
    input  logic [CODE_W-1:0] i_fern_code,
    input  logic              i_label_positive,
    input  logic              i_force_update,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [SUM_W-1:0]  o_confidence_sum,
    output logic              o_is_positive,
    output logic              o_was_updated,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [THR_W-1:0]  i_cfg_data
);

    t_state            r_state, n_state;
    logic [FERN_W-1:0] r_pos, n_pos;
    logic [FERN_W-1:0] r_fern, n_fern;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic              r_rd_pend;
    logic              r_cmd, r_label, r_force, r_upd, n_upd;
    logic [CNT_W-1:0]  r_p, n_p, r_n, n_n;
    logic [THR_W-1:0]  r_thr;
    logic              r_out_valid, n_out_valid;
    logic [SUM_W-1:0]  r_out_sum, n_out_sum;
    logic              r_out_pos, n_out_pos;
    logic              r_out_upd, n_out_upd;
    logic              out_load;
    logic [NUM_TESTS-1:0] r_code_buf [NUM_FERNS];

    logic              in_accept;
    t_tbl_req          tbl_req;
    t_entry            tbl_rd;
    logic              tbl_busy;
    t_div_req          div_req;
    logic              div_done;
    logic [POST_W-1:0] div_quo;

    logic [CMP_W-1:0]  sum_ext, limit;
    logic              at_least, at_most, do_upd;
    logic [ADDR_W-1:0] upd_addr;
    logic [DEN_W-1:0]  cnt_total;

    fpc_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (tbl_req),
        .o_rd_data (tbl_rd),
        .o_busy    (tbl_busy)
    );

    fpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign in_accept = i_in_valid && o_in_ready;
    assign upd_addr  = {r_fern, r_code_buf[r_fern]};

    // decision, exact compare of the sum against threshold * NUM_FERNS
    always_comb begin
        sum_ext  = CMP_W'(r_acc);
        limit    = CMP_W'(r_thr) * CMP_W'(NUM_FERNS);
        at_least = sum_ext >= limit;
        at_most  = sum_ext <= limit;
        do_upd   = r_cmd && (r_force || (r_label && at_most) || (!r_label && at_least));
        cnt_total = DEN_W'(r_p) + DEN_W'(r_n);
    end

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_fern      = r_fern;
        n_upd       = r_upd;
        n_p         = r_p;
        n_n         = r_n;
        n_acc       = r_rd_pend ? (r_acc + ACC_W'(tbl_rd.post)) : r_acc;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_sum   = r_out_sum;
        n_out_pos   = r_out_pos;
        n_out_upd   = r_out_upd;
        out_load    = 1'b0;
        o_in_ready  = 1'b0;
        tbl_req     = '0;
        div_req     = '0;

        unique case (r_state)
            S_CLEAR: begin
                if (!tbl_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                // ready is always high here, so valid alone marks the accepted word
                o_in_ready      = 1'b1;
                tbl_req.rd_en   = i_in_valid;
                tbl_req.rd_addr = {r_pos, i_fern_code[NUM_TESTS-1:0]};
                if (i_in_valid) begin
                    if (r_pos == FERN_W'(NUM_FERNS - 1)) begin
                        n_pos   = '0;
                        n_state = S_SUM;
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end
            end
            S_SUM: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_sum   = (sum_ext > CMP_W'(SUM_MAX)) ? SUM_MAX : SUM_W'(sum_ext);
                    n_out_pos   = at_least;
                    n_out_upd   = do_upd;
                    n_upd       = do_upd;
                    n_acc       = '0;
                    n_fern      = '0;
                    n_state     = do_upd ? S_UPD_RD : S_IDLE;
                end
            end
            S_UPD_RD: begin
                tbl_req.rd_en   = 1'b1;
                tbl_req.rd_addr = upd_addr;
                n_state         = S_UPD_CALC;
            end
            S_UPD_CALC: begin
                n_p = tbl_rd.pos_cnt;
                n_n = tbl_rd.neg_cnt;
                if (r_label) begin
                    if (tbl_rd.pos_cnt != CNT_MAX) begin
                        n_p = tbl_rd.pos_cnt + 1'b1;
                    end
                end else begin
                    if (tbl_rd.neg_cnt != CNT_MAX) begin
                        n_n = tbl_rd.neg_cnt + 1'b1;
                    end
                end
                n_state = S_UPD_PREP;
            end
            S_UPD_PREP: begin
                div_req.start  = 1'b1;
                div_req.num_hi = NUMHI_W'(r_p) * NUMHI_W'(SCALE) + NUMHI_W'(1);
                div_req.den    = cnt_total * DEN_W'(SCALE) + DEN_W'(1);
                n_state        = S_UPD_DIV;
            end
            S_UPD_DIV: begin
                if (div_done) begin
                    tbl_req.wr_en   = 1'b1;
                    tbl_req.wr_addr = upd_addr;
                    tbl_req.wr_data = '{post: div_quo, pos_cnt: r_p, neg_cnt: r_n};
                    if (r_fern == FERN_W'(NUM_FERNS - 1)) begin
                        n_upd   = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_fern  = r_fern + 1'b1;
                        n_state = S_UPD_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_pos       <= '0;
            r_fern      <= '0;
            r_acc       <= '0;
            r_rd_pend   <= 1'b0;
            r_upd       <= 1'b0;
            r_out_valid <= 1'b0;
            r_thr       <= THR_RESET;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_fern      <= n_fern;
            r_acc       <= n_acc;
            r_rd_pend   <= in_accept;
            r_upd       <= n_upd;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p       <= n_p;
        r_n       <= n_n;
        r_out_sum <= n_out_sum;
        r_out_pos <= n_out_pos;
        r_out_upd <= n_out_upd;
        if (in_accept) begin
            r_code_buf[r_pos] <= i_fern_code[NUM_TESTS-1:0];
            // only the last code's command fields count
            r_cmd   <= i_cmd;
            r_label <= i_label_positive;
            r_force <= i_force_update;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_confidence_sum = r_out_sum;
    assign o_is_positive    = r_out_pos;
    assign o_was_updated    = r_out_upd;
    assign o_cfg_ready      = 1'b1;

    a_start_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_pos == '0) |-> (r_acc == '0 && !r_rd_pend))
        else $error("sample started with a dirty accumulator");

    a_wr_only_learn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tbl_req.wr_en && !tbl_busy) |-> (r_upd && r_cmd && !in_accept))
        else $error("table write outside a learn update");

    a_quo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (div_quo <= POST_MAX))
        else $error("posterior above one");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before it was taken");

endmodule
